### rtl/pdpb_pkg.sv
// ----------------------------------------------------------------------------
// pdpb_pkg
// Shared types and constants for the parallel drive port bridge
// ----------------------------------------------------------------------------
package pdpb_pkg;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_COMMAND   = 2'd1,
    PH_SECONDARY = 2'd2,
    PH_OUTPUT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_COMMAND   = 3'd1,
    OP_SECONDARY = 3'd2,
    OP_DATA_OUT  = 3'd3,
    OP_DATA_IN   = 3'd4
  } bus_op_t;

  typedef enum logic [2:0] {
    RS_PORT_A  = 3'd0,
    RS_PORT_B  = 3'd1,
    RS_PORT_C  = 3'd2,
    RS_DIR_A   = 3'd3,
    RS_DIR_B   = 3'd4,
    RS_DIR_C   = 3'd5,
    RS_CONTROL = 3'd6,
    RS_UNUSED  = 3'd7
  } reg_sel_t;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_OK    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_ERROR = 8'd1;

  localparam logic [7:0] STATUS_OK_RESET    = 8'h00;
  localparam logic [7:0] STATUS_ERROR_RESET = 8'h03;

  localparam logic [7:0] DCMD_MASK      = 8'h8F;
  localparam logic [7:0] DCMD_COMMAND   = 8'h81;
  localparam logic [7:0] DCMD_SECONDARY = 8'h82;
  localparam logic [7:0] DCMD_OUTPUT    = 8'h83;
  localparam logic [7:0] DCMD_DATA_IN   = 8'h84;
  localparam logic [7:0] DCMD_STATUS_OK = 8'h85;

  localparam logic [7:0] DEV_BASE = 8'd9;

  localparam int unsigned HS_IN_BIT  = 6;
  localparam int unsigned HS_OUT_BIT = 7;
  localparam int unsigned DRIVE_BIT  = 5;

endpackage

### rtl/pdpb_if.sv
// ----------------------------------------------------------------------------
// pdpb_if
// Channel interfaces: bus access requests, results and configuration writes
// ----------------------------------------------------------------------------
interface pdpb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [5:0] addr;
  logic [7:0] wdata;
  logic       bus_fail;
  logic [7:0] bus_byte;

  modport source (output valid, cmd, addr, wdata, bus_fail, bus_byte, input ready);
  modport sink   (input valid, cmd, addr, wdata, bus_fail, bus_byte, output ready);
endinterface

interface pdpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic [2:0] bus_op;
  logic [7:0] bus_out_byte;

  modport source (output valid, rdata, bus_op, bus_out_byte, input ready);
  modport sink   (input valid, rdata, bus_op, bus_out_byte, output ready);
endinterface

interface pdpb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/parallel_drive_port_bridge.sv
// ----------------------------------------------------------------------------
// parallel_drive_port_bridge
// Emulated parallel drive port: register access decode and serial bus bridge
// ----------------------------------------------------------------------------
// an accepted transaction's result appears in the output register in the next cycle
// throughput: one transaction per cycle while the sink keeps taking results, set by the single output register stage
// the next transaction is taken while a result waits, as long as the sink takes it
// reset (rst, synchronous): phase idle, all port, direction, latch and status state zero,
// status codes at 0 and 3, output register empty
// ----------------------------------------------------------------------------
module parallel_drive_port_bridge (
  input logic          clk,
  input logic          rst,
  pdpb_in_if.sink      req,
  pdpb_out_if.source   rsp,
  pdpb_cfg_if.sink     cfg
);
  import pdpb_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] data_latch, data_latch_next;
  logic [7:0] status_byte, status_byte_next;
  logic [7:0] handshake_byte;
  logic [7:0] port_a, port_b, port_c;
  logic [7:0] dir_a, dir_b, dir_c;
  logic [7:0] control_byte;
  logic [7:0] status_ok_code, status_error_code;

  logic       out_valid;
  logic [7:0] out_rdata;
  bus_op_t    out_op;
  logic [7:0] out_byte;

  logic       in_fire;
  logic       is_write;
  reg_sel_t   rsel;
  logic       drive;
  logic [7:0] dcmd;
  logic [7:0] outcome;
  logic       port_a_wr;

  logic [7:0] rdata_c;
  bus_op_t    op_c;
  logic [7:0] obyte_c;

  assign req.ready = !out_valid || rsp.ready;
  assign in_fire   = req.valid && req.ready;
  assign is_write  = (req.cmd == CMD_WRITE);
  assign rsel      = reg_sel_t'(req.addr[2:0]);
  assign drive     = req.addr[DRIVE_BIT];
  assign dcmd      = req.wdata & DCMD_MASK;
  assign outcome   = req.bus_fail ? status_error_code : status_ok_code;
  assign port_a_wr = is_write && (rsel == RS_PORT_A);

  assign cfg.ready = 1'b1;

  // read mux
  always_comb begin
    unique case (rsel)
      RS_PORT_A:  rdata_c = (data_latch & ~dir_a) | (port_a & dir_a);
      RS_PORT_B:  rdata_c = (status_byte & ~dir_b) | (port_b & dir_b);
      RS_PORT_C:  rdata_c = (handshake_byte & ~dir_c) | (port_c & dir_c);
      RS_DIR_A:   rdata_c = dir_a;
      RS_DIR_B:   rdata_c = dir_b;
      RS_DIR_C:   rdata_c = dir_c;
      RS_CONTROL: rdata_c = control_byte;
      default:    rdata_c = 8'h00;
    endcase
    if (is_write) begin
      rdata_c = 8'h00;
    end
  end

  // command phase next state
  always_comb begin
    phase_next = phase;
    if (port_a_wr) begin
      if (phase == PH_IDLE) begin
        priority if (dcmd == DCMD_COMMAND) begin
          phase_next = PH_COMMAND;
        end else if (dcmd == DCMD_SECONDARY) begin
          phase_next = PH_SECONDARY;
        end else if (dcmd == DCMD_OUTPUT) begin
          phase_next = PH_OUTPUT;
        end else begin
          phase_next = PH_IDLE;
        end
      end else begin
        phase_next = PH_IDLE;
      end
    end
  end

  // bus transfer, status and latch
  always_comb begin
    op_c             = OP_NONE;
    obyte_c          = 8'h00;
    status_byte_next = status_byte;
    data_latch_next  = data_latch;
    if (port_a_wr) begin
      unique case (phase)
        PH_IDLE: begin
          if (dcmd == DCMD_DATA_IN) begin
            op_c             = OP_DATA_IN;
            status_byte_next = outcome;
            if (!req.bus_fail) begin
              data_latch_next = req.bus_byte;
            end
          end else if (dcmd == DCMD_STATUS_OK) begin
            status_byte_next = status_ok_code;
          end
        end
        PH_COMMAND: begin
          op_c             = OP_COMMAND;
          obyte_c          = req.wdata | (DEV_BASE - {7'b0, drive});
          status_byte_next = outcome;
        end
        PH_SECONDARY: begin
          op_c             = OP_SECONDARY;
          obyte_c          = req.wdata;
          status_byte_next = outcome;
        end
        PH_OUTPUT: begin
          op_c             = OP_DATA_OUT;
          obyte_c          = req.wdata;
          status_byte_next = outcome;
        end
        default: begin
          op_c = OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      data_latch        <= 8'h00;
      status_byte       <= 8'h00;
      handshake_byte    <= 8'h00;
      port_a            <= 8'h00;
      port_b            <= 8'h00;
      port_c            <= 8'h00;
      dir_a             <= 8'h00;
      dir_b             <= 8'h00;
      dir_c             <= 8'h00;
      control_byte      <= 8'h00;
      status_ok_code    <= STATUS_OK_RESET;
      status_error_code <= STATUS_ERROR_RESET;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == CFG_STATUS_OK) begin
          status_ok_code <= cfg.data;
        end else if (cfg.index == CFG_STATUS_ERROR) begin
          status_error_code <= cfg.data;
        end
      end
      if (in_fire) begin
        phase       <= phase_next;
        data_latch  <= data_latch_next;
        status_byte <= status_byte_next;
        if (is_write) begin
          unique case (rsel)
            RS_PORT_A:  port_a <= req.wdata;
            RS_PORT_B:  port_b <= req.wdata;
            RS_PORT_C: begin
              port_c         <= req.wdata;
              handshake_byte <= {~(req.wdata[HS_IN_BIT] & dir_c[HS_IN_BIT]), 7'b0};
            end
            RS_DIR_A:   dir_a <= req.wdata;
            RS_DIR_B:   dir_b <= req.wdata;
            RS_DIR_C:   dir_c <= req.wdata;
            RS_CONTROL: control_byte <= req.wdata;
            default: begin
            end
          endcase
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_rdata <= rdata_c;
      out_op    <= op_c;
      out_byte  <= obyte_c;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.rdata        = out_rdata;
  assign rsp.bus_op       = out_op;
  assign rsp.bus_out_byte = out_byte;

  // an armed phase always falls back to idle on the next port a write
  a_phase_return: assert property (@(posedge clk) disable iff (rst)
    in_fire && port_a_wr && phase != PH_IDLE |=> phase == PH_IDLE)
    else $error("armed phase did not return to idle");

  // every accepted transaction leaves a result behind
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  // bus transfers only come from writes, so read data is zero with them
  a_op_no_rdata: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_op != OP_NONE |-> out_rdata == 8'h00)
    else $error("bus transfer carries read data");

  // a data-in request or no transfer sends no byte
  a_op_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_op == OP_NONE || out_op == OP_DATA_IN) |-> out_byte == 8'h00)
    else $error("byte sent without an outgoing transfer");

endmodule
